// ----- rtl/minv3_pkg.sv -----
// Shared types and constants for the 3x3 fixed-point matrix inverse block.
package minv3_pkg;

  localparam int unsigned EntryW = 32;
  localparam int unsigned FracW = 16;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusSingular  = 2'd1,
    StatusSaturated = 2'd2,
    StatusReserved  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [EntryW-1:0] row0_col0;
    logic signed [EntryW-1:0] row0_col1;
    logic signed [EntryW-1:0] row0_col2;
    logic signed [EntryW-1:0] row1_col0;
    logic signed [EntryW-1:0] row1_col1;
    logic signed [EntryW-1:0] row1_col2;
    logic signed [EntryW-1:0] row2_col0;
    logic signed [EntryW-1:0] row2_col1;
    logic signed [EntryW-1:0] row2_col2;
  } mat_in_t;

  typedef struct packed {
    logic signed [EntryW-1:0] inv_row0_col0;
    logic signed [EntryW-1:0] inv_row0_col1;
    logic signed [EntryW-1:0] inv_row0_col2;
    logic signed [EntryW-1:0] inv_row1_col0;
    logic signed [EntryW-1:0] inv_row1_col1;
    logic signed [EntryW-1:0] inv_row1_col2;
    logic signed [EntryW-1:0] inv_row2_col0;
    logic signed [EntryW-1:0] inv_row2_col1;
    logic signed [EntryW-1:0] inv_row2_col2;
    logic [1:0]               status;
  } mat_out_t;

endpackage

// ----- rtl/minv3_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, signed and saturated.
module minv3_div #(
  parameter int unsigned NumW = 99,
  parameter int unsigned DenW = 99,
  parameter int unsigned QW   = 34,
  parameter int unsigned OutW = 32,
  parameter int unsigned TagW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  input  logic              neg_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              valid_o,
  output logic [OutW-1:0]   quo_o,
  output logic              sat_o,
  output logic [TagW-1:0]   tag_o
);

  // The numerator bits above the low QW bits preload the partial remainder.
  // When that high part is not below the denominator, the quotient needs more
  // than QW bits and the result saturates; otherwise QW stages give it exactly.
  localparam int unsigned RemW = DenW + 1;

  logic                   vld_q [QW+1];
  logic [RemW-1:0]        rem_q [QW+1];
  logic [QW-1:0]          lo_q  [QW+1];
  logic [DenW-1:0]        den_q [QW+1];
  logic [QW-1:0]          quo_q [QW+1];
  logic                   neg_q [QW+1];
  logic                   ovf_q [QW+1];
  logic [TagW-1:0]        tag_q [QW+1];

  always_comb begin
    vld_q[0] = valid_i;
    rem_q[0] = RemW'(num_i[NumW-1:QW]);
    lo_q[0]  = num_i[QW-1:0];
    den_q[0] = den_i;
    quo_q[0] = '0;
    neg_q[0] = neg_i;
    ovf_q[0] = (DenW'(num_i[NumW-1:QW]) >= den_i);
    tag_q[0] = tag_i;
  end

  // Each stage shifts in one numerator bit and subtracts when it fits.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RemW-1:0] sh_d;
    logic [RemW:0]   diff_d;
    logic [QW-1:0]   lo_d;
    always_comb begin
      lo_d   = lo_q[s];
      sh_d   = {rem_q[s][RemW-2:0], lo_d[QW-1-s]};
      diff_d = {1'b0, sh_d} - {2'b0, den_q[s]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= diff_d[RemW] ? sh_d : diff_d[RemW-1:0];
      quo_q[s+1] <= {quo_q[s][QW-2:0], ~diff_d[RemW]};
      lo_q[s+1]  <= lo_q[s];
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      ovf_q[s+1] <= ovf_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  // Final stage: sign and saturate.
  logic [QW-1:0] lim_d;
  logic [QW-1:0] mag_d;
  logic          sat_d;
  logic [OutW-1:0] res_d;
  logic [OutW-1:0] res_q;
  logic            sat_q;
  logic            vld_o_q;
  logic [TagW-1:0] tag_o_q;

  always_comb begin
    lim_d = QW'(1) << (OutW - 1);
    mag_d = quo_q[QW];
    if (neg_q[QW]) begin
      sat_d = ovf_q[QW] || (mag_d > lim_d);
      res_d = sat_d ? {1'b1, {(OutW-1){1'b0}}} : OutW'(~mag_d + QW'(1));
    end else begin
      sat_d = ovf_q[QW] || (mag_d >= lim_d);
      res_d = sat_d ? {1'b0, {(OutW-1){1'b1}}} : mag_d[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else begin
      vld_o_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    sat_q   <= sat_d;
    tag_o_q <= tag_q[QW];
  end

  assign valid_o = vld_o_q;
  assign quo_o   = res_q;
  assign sat_o   = sat_q;
  assign tag_o   = tag_o_q;

endmodule

// ----- rtl/matrix_inverse_3x3_top.sv -----
// Top level of the pipelined 3x3 fixed-point matrix inverse.
// A new matrix may start in every cycle; busy_o is always low. Each result
// appears on result_o for one cycle with done_o high. Its start beat passes
// through these stages in order: six stages form the minors and determinant
// and prepare the division, the nine pipelined restoring dividers retire one
// quotient bit per stage over EntryW + 2 stages, one stage signs and saturates,
// and one registers the output.
// The receiver cannot stall the block, so results must be taken as they come.
module matrix_inverse_3x3_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  minv3_pkg::mat_in_t  matrix_i,
  output logic                done_o,
  output minv3_pkg::mat_out_t result_o
);
  import minv3_pkg::*;

  localparam int unsigned W   = EntryW;
  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned PW  = 2 * W + 1;      // cofactor width
  localparam int unsigned DW  = 3 * W + 2;      // determinant width
  localparam int unsigned NW  = PW + 2 * F + 2; // shifted numerator width
  localparam int unsigned QW  = W + 2;          // quotient magnitude width

  logic signed [W-1:0] m_d [9];
  always_comb begin
    m_d[0] = W'(matrix_i.row0_col0); m_d[1] = W'(matrix_i.row0_col1);
    m_d[2] = W'(matrix_i.row0_col2); m_d[3] = W'(matrix_i.row1_col0);
    m_d[4] = W'(matrix_i.row1_col1); m_d[5] = W'(matrix_i.row1_col2);
    m_d[6] = W'(matrix_i.row2_col0); m_d[7] = W'(matrix_i.row2_col1);
    m_d[8] = W'(matrix_i.row2_col2);
  end

  // Stage 1: the eighteen products of the cofactors.
  localparam int unsigned IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned IX [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned IY [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [2*W-1:0] pa_q [9];
  logic signed [2*W-1:0] px_q [9];
  logic signed [W-1:0]   r1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      v1_q <= start_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      pa_q[i] <= m_d[IA[i]] * m_d[IB[i]];
      px_q[i] <= m_d[IX[i]] * m_d[IY[i]];
    end
    for (int i = 0; i < 3; i++) r1_q[i] <= m_d[i];
  end

  // Stage 2: cofactors.
  logic signed [PW-1:0] c2_q [9];
  logic signed [W-1:0]  r2_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      c2_q[i] <= PW'(pa_q[i]) - PW'(px_q[i]);
    end
    r2_q <= r1_q;
  end

  // Stage 3: determinant partial products. Each cofactor of column zero is
  // split into a signed high part and an unsigned low part of W + 1 bits.
  logic signed [2*W-1:0] th3_q [3];
  logic signed [2*W+1:0] tl3_q [3];
  logic signed [PW-1:0]  c3_q [9];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      th3_q[i] <= r2_q[i] * $signed(c2_q[3*i][PW-1:W+1]);
      tl3_q[i] <= r2_q[i] * $signed({1'b0, c2_q[3*i][W:0]});
    end
    c3_q <= c2_q;
  end

  // Stage 4: determinant terms from the partial products.
  logic signed [DW-1:0] t4_q [3];
  logic signed [PW-1:0] c4_q [9];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t4_q[i] <= (DW'(th3_q[i]) <<< (W + 1)) + DW'(tl3_q[i]);
    end
    c4_q <= c3_q;
  end

  // Stage 5: determinant sum.
  logic signed [DW-1:0] det5_q;
  logic signed [PW-1:0] c5_q [9];
  always_ff @(posedge clk_i) begin
    det5_q <= t4_q[0] + t4_q[1] + t4_q[2];
    c5_q   <= c4_q;
  end

  // Stage 6: magnitudes and the rounded numerator 2|C|*2^(2F) + |D|.
  logic                 v6_q;
  logic [NW-1:0]        n6_q [9];
  logic [DW:0]          d6_q;
  logic                 ng6_q [9];
  logic                 z6_q;
  logic [DW-1:0]        dabs_d;

  always_comb begin
    dabs_d = det5_q[DW-1] ? DW'(-det5_q) : DW'(det5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      n6_q[i] <= (NW'(c5_q[i][PW-1] ? PW'(-c5_q[i]) : PW'(c5_q[i])) << (2 * F + 1))
                 + NW'(dabs_d);
      ng6_q[i] <= c5_q[i][PW-1] ^ det5_q[DW-1];
    end
    d6_q <= {dabs_d, 1'b0};
    z6_q <= (det5_q == '0);
  end

  // Dividers: the high numerator bits preload the remainder and the low QW
  // bits are shifted through, one quotient bit per stage.
  logic [8:0]   dv_d;
  logic [W-1:0] q_d [9];
  logic [8:0]   s_d;
  logic         z_d [9];

  for (genvar g = 0; g < 9; g++) begin : g_div
    minv3_div #(
      .NumW(NW), .DenW(DW + 1), .QW(QW), .OutW(W), .TagW(1)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v6_q),
      .num_i   (n6_q[g]),
      .den_i   (d6_q),
      .neg_i   (ng6_q[g]),
      .tag_i   (z6_q),
      .valid_o (dv_d[g]),
      .quo_o   (q_d[g]),
      .sat_o   (s_d[g]),
      .tag_o   (z_d[g])
    );
  end

  // Output register with the singular override and status code.
  logic     done_q;
  mat_out_t res_q;
  logic [W-1:0] e_d [9];
  logic         sing_d;

  always_comb begin
    sing_d = z_d[0];
    for (int i = 0; i < 9; i++) e_d[i] = sing_d ? '0 : q_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_d[0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.inv_row0_col0 <= EntryW'(e_d[0]);
    res_q.inv_row0_col1 <= EntryW'(e_d[1]);
    res_q.inv_row0_col2 <= EntryW'(e_d[2]);
    res_q.inv_row1_col0 <= EntryW'(e_d[3]);
    res_q.inv_row1_col1 <= EntryW'(e_d[4]);
    res_q.inv_row1_col2 <= EntryW'(e_d[5]);
    res_q.inv_row2_col0 <= EntryW'(e_d[6]);
    res_q.inv_row2_col1 <= EntryW'(e_d[7]);
    res_q.inv_row2_col2 <= EntryW'(e_d[8]);
    if (sing_d) begin
      res_q.status <= StatusSingular;
    end else if (|s_d) begin
      res_q.status <= StatusSaturated;
    end else begin
      res_q.status <= StatusOk;
    end
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- dv/matrix_inverse_3x3_top_tb.sv -----
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
module matrix_inverse_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import minv3_pkg::*;

  localparam int unsigned Latency = EntryW + 10;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1750;
  localparam int unsigned FracShift = 2 * FracW + 1;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [EntryW-1:0] entry_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  mat_in_t  matrix_i;
  logic     done_o;
  mat_out_t result_o;

  mat_out_t inverse_q[$];
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned singular_seen;
  int unsigned saturated_seen;
  int unsigned cycles;
  bit          no_idle;

  matrix_inverse_3x3_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .matrix_i (matrix_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Free-running clock, 4 ns period.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Rounded, saturated quotient of a cofactor by the determinant.
  function automatic entry_t round_quotient(input wide_t cof, input wide_t det,
                                            output bit sat);
    logic [255:0] num;
    logic [255:0] den;
    logic [255:0] quo;
    bit           neg;
    neg = cof[255] ^ det[255];
    num = cof[255] ? -cof : cof;
    den = det[255] ? -det : det;
    num = (num << FracShift) + den;
    den = den << 1;
    quo = num / den;
    sat = 1'b0;
    if (neg && quo > (256'd1 << (EntryW - 1))) begin
      sat = 1'b1;
      return {1'b1, {(EntryW-1){1'b0}}};
    end
    if (!neg && quo >= (256'd1 << (EntryW - 1))) begin
      sat = 1'b1;
      return {1'b0, {(EntryW-1){1'b1}}};
    end
    return neg ? entry_t'(-quo) : entry_t'(quo);
  endfunction

  // Inverse by the adjugate at full width.
  function automatic mat_out_t invert_matrix(input mat_in_t mat);
    wide_t    m[9];
    wide_t    c[9];
    wide_t    det;
    entry_t   inv[9];
    bit       sat;
    bit       any_sat;
    mat_out_t res;
    m[0] = mat.row0_col0; m[1] = mat.row0_col1; m[2] = mat.row0_col2;
    m[3] = mat.row1_col0; m[4] = mat.row1_col1; m[5] = mat.row1_col2;
    m[6] = mat.row2_col0; m[7] = mat.row2_col1; m[8] = mat.row2_col2;
    c[0] = m[4] * m[8] - m[5] * m[7];
    c[1] = m[2] * m[7] - m[1] * m[8];
    c[2] = m[1] * m[5] - m[2] * m[4];
    c[3] = m[5] * m[6] - m[3] * m[8];
    c[4] = m[0] * m[8] - m[2] * m[6];
    c[5] = m[2] * m[3] - m[0] * m[5];
    c[6] = m[3] * m[7] - m[4] * m[6];
    c[7] = m[1] * m[6] - m[0] * m[7];
    c[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
    any_sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (det == 0) begin
        inv[i] = '0;
      end else begin
        inv[i] = round_quotient(c[i], det, sat);
        any_sat |= sat;
      end
    end
    res = {inv[0], inv[1], inv[2], inv[3], inv[4], inv[5], inv[6], inv[7], inv[8],
           2'b00};
    if (det == 0) res.status = StatusSingular;
    else if (any_sat) res.status = StatusSaturated;
    else res.status = StatusOk;
    return res;
  endfunction

  function automatic mat_in_t pack_matrix(input entry_t e[9]);
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  // Send one matrix beat, then maybe leave a one-cycle gap.
  task automatic send_matrix(input mat_in_t mat);
    @(negedge clk_i);
    start_i  <= 1'b1;
    matrix_i <= mat;
    do @(posedge clk_i); while (busy_o);
    inverse_q.push_back(invert_matrix(mat));
    beats_sent++;
    if (!no_idle && $urandom_range(99) < 11) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
  endtask

  // Check every result beat against the oldest expectation.
  always @(posedge clk_i) begin
    mat_out_t want;
    bit       bad;
    if (rst_ni && done_o) begin
      results_seen++;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %h", result_o);
      end else begin
        want = inverse_q.pop_front();
        bad = 1'b0;
        for (int k = 0; k < 9; k++) begin
          if (result_o[289-32*k -: 32] !== want[289-32*k -: 32]) begin
            bad = 1'b1;
            if (mismatches < 10)
              $display("Entry %0d mismatch: expected %h, got %h", k,
                       want[289-32*k -: 32], result_o[289-32*k -: 32]);
          end
        end
        if (result_o.status !== want.status) begin
          bad = 1'b1;
          if (mismatches < 10)
            $display("Status mismatch: expected %0d, got %0d", want.status,
                     result_o.status);
        end
        if (bad) mismatches++;
        if (want.status == StatusSingular) singular_seen++;
        if (want.status == StatusSaturated) saturated_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic entry_t fixed(input int whole);
    return entry_t'(whole <<< FracW);
  endfunction

  // Corners: identity, zero, extreme entries, ties and saturation.
  task automatic test_directed();
    entry_t e[9];
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? fixed(1) : '0;
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = '0;
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? fixed(2) : '0;
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? fixed(-3) : '0;
    send_matrix(pack_matrix(e));
    // Smallest diagonal: the inverse overflows in both directions.
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? entry_t'(1) : '0;
    send_matrix(pack_matrix(e));
    e[0] = -1;
    send_matrix(pack_matrix(e));
    // Most negative and most positive entries, everywhere or on the diagonal, then all -1.
    for (int i = 0; i < 9; i++) e[i] = {1'b1, {(EntryW-1){1'b0}}};
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? {1'b1, {(EntryW-1){1'b0}}}
                                                    : {1'b0, {(EntryW-1){1'b1}}};
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? {1'b0, {(EntryW-1){1'b1}}} : '0;
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = '1;
    send_matrix(pack_matrix(e));
    // Rank-two matrix: singular with nonzero entries.
    for (int i = 0; i < 9; i++) e[i] = fixed(i + 1);
    send_matrix(pack_matrix(e));
    // Diagonal 3 and 1/3-like values give exact and near ties.
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? fixed(3) : '0;
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? entry_t'(32'sh0002_0000 <<< 15) : '0;
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? entry_t'(-(1 <<< 17)) : entry_t'(1);
    send_matrix(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = entry_t'($urandom_range(7) << (FracW - 1)) - fixed(2);
    send_matrix(pack_matrix(e));
  endtask

  // Sender holds off until every expected result has arrived.
  task automatic test_drain_pause();
    entry_t e[9];
    drain_results();
    for (int i = 0; i < 9; i++) e[i] = fixed($urandom_range(8)) - fixed(4);
    send_matrix(pack_matrix(e));
  endtask

  // Random matrices of several kinds, with a stretch of back-to-back beats.
  task automatic test_random();
    entry_t e[9];
    int     kind;
    for (int n = 0; n < RandomItems; n++) begin
      no_idle = (n >= 600 && n < 900);
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
        case (kind)
          0, 1: e[i] = entry_t'($urandom);
          2, 3, 4: e[i] = entry_t'($signed($urandom_range(2 * (1 << 19))) - (1 << 19));
          5: e[i] = entry_t'($signed($urandom_range(2 * (1 << 10))) - (1 << 10));
          6: e[i] = entry_t'($urandom) >>> $urandom_range(31);
          7: e[i] = fixed($urandom_range(4)) - fixed(2);
          default: e[i] = entry_t'($signed($urandom_range(2 * (1 << 17))) - (1 << 17));
        endcase
      end
      // Copy a row or column now and then to force a zero determinant.
      if (kind == 8) begin
        for (int i = 0; i < 3; i++) e[6 + i] = e[i];
      end else if (kind == 9) begin
        for (int i = 0; i < 3; i++) e[3*i + 2] = e[3*i];
      end
      send_matrix(pack_matrix(e));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    beats_sent = 0;
    results_seen = 0;
    singular_seen = 0;
    saturated_seen = 0;
    cycles = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    matrix_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_drain_pause();
    test_random();
    drain_results();
    repeat (Latency + 10) @(posedge clk_i);
    if (inverse_q.size() != 0) mismatches++;
    $display("Sent %0d matrices and checked %0d inverses (%0d singular, %0d saturated).",
             beats_sent, results_seen, singular_seen, saturated_seen);
    $display("Covered extreme entries, singular and saturating inverses, gaps and a drain.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/minv3_pkg.sv
rtl/minv3_div.sv
rtl/matrix_inverse_3x3_top.sv
dv/matrix_inverse_3x3_top_tb.sv
